// ===== rtl/ppda_pkg.sv =====
package ppda_pkg;

  localparam int RING_LENGTH_DEF = 10;
  localparam int QUEUE_DEPTH     = 2;
  localparam int CFG_W           = 32;
  localparam int CAP_W           = 16;
  localparam int OVF_W           = 16;
  localparam int TIME_W          = 32;
  localparam int FILL_W          = 4;
  localparam int IN_DATA_W       = 16;
  localparam int OUT_DATA_W      = 136;

  localparam logic [CFG_W-1:0] MIN_INTERVAL_RST = 32'd12500;

  typedef enum logic {
    CMD_TICK    = 1'b0,
    CMD_CAPTURE = 1'b1
  } ppda_cmd_t;

  typedef struct packed {
    logic              is_capture;
    logic              accepted;
    logic [TIME_W-1:0] delta;
  } ppda_item_t;

endpackage

// ===== rtl/ppda_front.sv =====
module ppda_front
  import ppda_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic                 in_tuser,
  input  logic                 q_full,
  output logic                 q_push,
  output ppda_item_t           q_item
);

  logic [CFG_W-1:0]  min_r;
  logic [OVF_W-1:0]  ovf_r;
  logic [TIME_W-1:0] prev_r;
  logic [TIME_W-1:0] now_w;
  logic [TIME_W-1:0] delta_w;
  logic              is_cap_w;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready;

  assign is_cap_w = (ppda_cmd_t'(in_tuser) == CMD_CAPTURE);
  assign now_w    = {ovf_r, in_tdata[CAP_W-1:0]};
  assign delta_w  = now_w - prev_r;

  always_comb begin
    q_item.is_capture = is_cap_w;
    q_item.accepted   = is_cap_w && (delta_w >= min_r);
    q_item.delta      = is_cap_w ? delta_w : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r  <= MIN_INTERVAL_RST;
      ovf_r  <= '0;
      prev_r <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        min_r <= cfg_data;
      end
      if (q_push) begin
        if (is_cap_w) begin
          prev_r <= now_w;
        end else begin
          ovf_r <= ovf_r + OVF_W'(1);
        end
      end
    end
  end

endmodule

// ===== rtl/ppda_queue.sv =====
module ppda_queue
  import ppda_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  ppda_item_t push_item,
  output logic       full,
  input  logic       pop,
  output logic       pop_valid,
  output ppda_item_t pop_item
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  ppda_item_t       slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full      = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_item  = slot_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push && !full) begin
        slot_r[wr_ptr_r] <= push_item;
        wr_ptr_r         <= ptr_inc(wr_ptr_r);
      end
      if (pop && pop_valid) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      unique case ({push && !full, pop && pop_valid})
        2'b10:   cnt_r <= cnt_r + CNT_W'(1);
        2'b01:   cnt_r <= cnt_r - CNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== rtl/ppda_div.sv =====
module ppda_div #(
  parameter int NW = 36,
  parameter int DW = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);

  localparam int CNT_W = $clog2(NW + 1);

  logic [NW-1:0]    q_r;
  logic [DW-1:0]    rem_r;
  logic [DW-1:0]    dsr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DW:0]      shifted;
  logic             ge;
  logic [DW:0]      diff;

  assign shifted  = {rem_r, q_r[NW-1]};
  assign ge       = (shifted >= {1'b0, dsr_r});
  assign diff     = shifted - {1'b0, dsr_r};
  assign done     = done_r;
  assign quotient = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NW);
        q_r    <= dividend;
        rem_r  <= '0;
        dsr_r  <= divisor;
      end else if (busy_r) begin
        q_r   <= {q_r[NW-2:0], ge};
        rem_r <= ge ? diff[DW-1:0] : shifted[DW-1:0];
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/ppda_back.sv =====
module ppda_back
  import ppda_pkg::*;
#(
  parameter int RING_LENGTH = RING_LENGTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  ppda_item_t            q_item,
  output logic                  q_pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int CW     = $clog2(RING_LENGTH + 1);
  localparam int SLOT_W = (RING_LENGTH > 1) ? $clog2(RING_LENGTH) : 1;
  localparam int SW     = TIME_W + CW;
  localparam int PAD_W  = OUT_DATA_W - (3 * TIME_W + TIME_W + 1 + FILL_W + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_MEAN,
    S_DIV,
    S_OUT
  } state_t;

  state_t            state_r;
  ppda_item_t        item_r;
  logic [TIME_W-1:0] ring_mem [RING_LENGTH];
  logic [TIME_W-1:0] rd_data_r;
  logic [RING_LENGTH-1:0] valid_r;
  logic [SLOT_W-1:0] slot_r;
  logic [CW-1:0]     fill_r;
  logic [CW-1:0]     nonzero_r;
  logic [SW-1:0]     sum_r;
  logic [TIME_W-1:0] hit_r;
  logic [TIME_W-1:0] last_r;
  logic [TIME_W-1:0] mean_r;
  logic              out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic [TIME_W-1:0] old_w;
  logic [SW-1:0]     sum_nxt;
  logic [CW-1:0]     nonzero_nxt;
  logic              div_start;
  logic              div_done;
  logic [SW-1:0]     div_q;

  assign q_pop      = (state_r == S_IDLE) && q_valid;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign div_start  = (state_r == S_MEAN) && (nonzero_r != '0);

  assign old_w = valid_r[slot_r] ? rd_data_r : '0;

  always_comb begin
    sum_nxt     = sum_r - SW'(old_w) + SW'(item_r.delta);
    nonzero_nxt = nonzero_r - CW'(old_w != '0) + CW'(item_r.delta != '0);
  end

  ppda_div #(
    .NW(SW),
    .DW(CW)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(sum_r),
    .divisor (nonzero_r),
    .done    (div_done),
    .quotient(div_q)
  );

  always_ff @(posedge clk) begin
    rd_data_r <= ring_mem[slot_r];
    if (state_r == S_RD) begin
      ring_mem[slot_r] <= item_r.delta;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      slot_r      <= '0;
      fill_r      <= '0;
      nonzero_r   <= '0;
      sum_r       <= '0;
      hit_r       <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            item_r  <= q_item;
            state_r <= q_item.accepted ? S_RD : S_MEAN;
          end
        end
        S_RD: begin
          valid_r[slot_r] <= 1'b1;
          sum_r           <= sum_nxt;
          nonzero_r       <= nonzero_nxt;
          slot_r          <= (slot_r == SLOT_W'(RING_LENGTH - 1)) ? '0 : slot_r + SLOT_W'(1);
          if (fill_r != CW'(RING_LENGTH)) begin
            fill_r <= fill_r + CW'(1);
          end
          hit_r   <= hit_r + TIME_W'(1);
          last_r  <= item_r.delta;
          state_r <= S_MEAN;
        end
        S_MEAN: begin
          if (nonzero_r == '0) begin
            mean_r  <= '0;
            state_r <= S_OUT;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            mean_r  <= div_q[TIME_W-1:0];
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {{PAD_W{1'b0}}, mean_r, (fill_r == CW'(RING_LENGTH)),
                            FILL_W'(fill_r), hit_r, last_r, item_r.delta, item_r.accepted};
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(RING_LENGTH))
    else $error("fill count beyond ring length");
  a_nonzero_le_fill: assert property (@(posedge clk) disable iff (!rst_n)
    nonzero_r <= fill_r)
    else $error("nonzero count exceeds fill count");
  a_sum_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (nonzero_r == '0) |-> (sum_r == '0))
    else $error("period sum nonzero with no nonzero entries");
  a_acc_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[0]) |-> (fill_r != '0))
    else $error("accepted word reported with empty ring");
`endif

endmodule

// ===== rtl/pulse_period_debounce_average_top.sv =====
// Path: a stored edge runs S_IDLE, S_RD, S_MEAN, S_DIV and S_OUT; other words skip S_RD,
//   and S_DIV is skipped when no nonzero period is held. SW = 32 + clog2(RING_LENGTH+1),
//   36 by default, sizes the one-bit-per-cycle restoring divider for the mean. The back
//   takes one word at a time, an untaken result word holds it; the two-word queue takes words ahead.
// Reset: synchronous, active low; all counters, sums and the ring valid bits clear at once,
//   no clearing pass, and the debounce register returns to 12500.
module pulse_period_debounce_average_top
  import ppda_pkg::*;
#(
  parameter int RING_LENGTH = RING_LENGTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_W-1:0]      cfg_data,      // min_interval_ticks
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,      // [15:0] capture_value
  input  logic                  in_tuser,      // [0] cmd
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [0] accepted, [32:1] edge_delta, [64:33] latest_period, [96:65] accepted_count,
  // [100:97] fill_level, [101] ring_full, [133:102] mean_period, [135:134] zero
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic       q_full;
  logic       q_push;
  ppda_item_t q_in;
  logic       q_pop;
  logic       q_valid;
  ppda_item_t q_out;

  ppda_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_in)
  );

  ppda_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_item(q_in),
    .full     (q_full),
    .pop      (q_pop),
    .pop_valid(q_valid),
    .pop_item (q_out)
  );

  ppda_back #(
    .RING_LENGTH(RING_LENGTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_out),
    .q_pop     (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

endmodule
